[rtl/core/point_segment_distance_defines.svh]
// ============================================================================
// Assertion macros for the point-to-segment distance block
// Shared concurrent assertion forms used by the top level.
// ============================================================================
`ifndef POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_DEFINES_SVH

// Checks that a condition implies a consequence on the same edge.
`define PSD_ASSERT_IMPL(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define PSD_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/psd_pkg.sv]
// ============================================================================
// Point-to-segment distance package
// Shared fraction width and region codes for the distance pipeline.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // Coordinates are signed fixed point with this many fraction bits.
    localparam int FRAC_BITS = 16;

    localparam logic [1:0] REGION_INTERIOR  = 2'd0;
    localparam logic [1:0] REGION_START     = 2'd1;
    localparam logic [1:0] REGION_END       = 2'd2;
    localparam logic [1:0] REGION_SATURATED = 2'd3;

endpackage

`default_nettype wire

[rtl/core/point_segment_distance.sv]
// ============================================================================
// Point-to-segment distance pipeline
// Path to m_tvalid: stages 1 to 4, 4b, the divider pipeline, stages 5 and 6, the square root pipeline, output register.
// Throughput: one request per cycle; a result-side stall holds every stage in place.
// Reset clears only the valid bits of the stages; data registers are not reset.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "point_segment_distance_defines.svh"

module point_segment_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // mode, query_x, query_y, start_x, start_y, end_x, end_y, zero padding
    input  wire logic [((6*COORD_WIDTH+1+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // distance, closest_x, closest_y, region, zero padding
    output logic [((3*COORD_WIDTH+3+7)/8)*8-1:0] m_tdata
);

    localparam int CW = COORD_WIDTH;
    localparam int EW = CW + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 1;
    localparam int NW = EW + DW;
    localparam int SW = 2 * (EW + 1) + 2;
    localparam int RW = SW / 2;
    localparam int QW = CW + 3;
    localparam int LAT_DIV = NW;
    localparam int LAT_SQ = RW;
    localparam int OW = ((3*CW+3+7)/8)*8;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic sx_acc;
    assign sx_acc = s_tvalid && s_tready;

    // Stage 1: differences.
    logic                 v1_reg;
    logic                 mode1_reg;
    logic signed [CW-1:0] px1_reg, py1_reg, ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [EW-1:0] dx1_reg, dy1_reg, ex1_reg, ey1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= sx_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= s_tdata[0];
            px1_reg <= s_tdata[1+0*CW +: CW];
            py1_reg <= s_tdata[1+1*CW +: CW];
            ax1_reg <= s_tdata[1+2*CW +: CW];
            ay1_reg <= s_tdata[1+3*CW +: CW];
            bx1_reg <= s_tdata[1+4*CW +: CW];
            by1_reg <= s_tdata[1+5*CW +: CW];
            dx1_reg <= EW'(signed'(s_tdata[1+4*CW +: CW])) - EW'(signed'(s_tdata[1+2*CW +: CW]));
            dy1_reg <= EW'(signed'(s_tdata[1+5*CW +: CW])) - EW'(signed'(s_tdata[1+3*CW +: CW]));
            ex1_reg <= EW'(signed'(s_tdata[1+0*CW +: CW])) - EW'(signed'(s_tdata[1+2*CW +: CW]));
            ey1_reg <= EW'(signed'(s_tdata[1+1*CW +: CW])) - EW'(signed'(s_tdata[1+3*CW +: CW]));
        end
    end

    // Stage 2: products.
    logic                 v2_reg, mode2_reg;
    logic signed [CW-1:0] px2_reg, py2_reg, ax2_reg, ay2_reg, bx2_reg, by2_reg;
    logic signed [EW-1:0] dx2_reg, dy2_reg;
    logic signed [PW-1:0] xx2_reg, yy2_reg, ex2_reg, ey2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode2_reg <= mode1_reg;
            px2_reg <= px1_reg; py2_reg <= py1_reg;
            ax2_reg <= ax1_reg; ay2_reg <= ay1_reg;
            bx2_reg <= bx1_reg; by2_reg <= by1_reg;
            dx2_reg <= dx1_reg; dy2_reg <= dy1_reg;
            xx2_reg <= PW'(dx1_reg) * PW'(dx1_reg);
            yy2_reg <= PW'(dy1_reg) * PW'(dy1_reg);
            ex2_reg <= PW'(ex1_reg) * PW'(dx1_reg);
            ey2_reg <= PW'(ey1_reg) * PW'(dy1_reg);
        end
    end

    // Stage 3: numerator and denominator.
    logic                 v3_reg, mode3_reg;
    logic signed [CW-1:0] px3_reg, py3_reg, ax3_reg, ay3_reg, bx3_reg, by3_reg;
    logic signed [EW-1:0] dx3_reg, dy3_reg;
    logic signed [DW-1:0] num3_reg;
    logic        [DW-1:0] den3_reg;
    logic signed [DW-1:0] num3_next;
    logic        [DW-1:0] den3_next;

    always_comb begin
        num3_next = DW'(ex2_reg) + DW'(ey2_reg);
        den3_next = DW'(unsigned'(xx2_reg)) + DW'(unsigned'(yy2_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode3_reg <= mode2_reg;
            px3_reg <= px2_reg; py3_reg <= py2_reg;
            ax3_reg <= ax2_reg; ay3_reg <= ay2_reg;
            bx3_reg <= bx2_reg; by3_reg <= by2_reg;
            dx3_reg <= dx2_reg; dy3_reg <= dy2_reg;
            num3_reg <= num3_next;
            den3_reg <= den3_next;
        end
    end

    // Stage 4: classify and form the partial products of the two dividends |d*num|.
    localparam int NL = (DW + 1) / 2;
    localparam int NH = DW - NL;
    localparam int LPW = EW + NL;
    localparam int HPW = EW + NH;

    logic [1:0] reg4_class;
    logic       neg4x, neg4y;
    logic [DW-1:0] nummag;
    logic [EW-1:0] dxm, dym;

    always_comb begin
        nummag = num3_reg[DW-1] ? DW'(-num3_reg) : DW'(num3_reg);
        dxm = dx3_reg[EW-1] ? EW'(-dx3_reg) : EW'(dx3_reg);
        dym = dy3_reg[EW-1] ? EW'(-dy3_reg) : EW'(dy3_reg);
        if (den3_reg == '0) begin
            reg4_class = psd_pkg::REGION_START;
        end else if (!mode3_reg && num3_reg[DW-1]) begin
            reg4_class = psd_pkg::REGION_START;
        end else if (!mode3_reg && (nummag > den3_reg)) begin
            reg4_class = psd_pkg::REGION_END;
        end else begin
            reg4_class = psd_pkg::REGION_INTERIOR;
        end
        neg4x = dx3_reg[EW-1] ^ num3_reg[DW-1];
        neg4y = dy3_reg[EW-1] ^ num3_reg[DW-1];
    end

    logic                 v4_reg;
    logic [1:0]           cls4_reg;
    logic                 nx4s_reg, ny4s_reg;
    logic signed [CW-1:0] px4_reg, py4_reg, ax4_reg, ay4_reg, bx4_reg, by4_reg;
    logic [DW-1:0]        den4_reg;
    logic [LPW-1:0]       mxl4_reg, myl4_reg;
    logic [HPW-1:0]       mxh4_reg, myh4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls4_reg <= reg4_class;
            nx4s_reg <= neg4x; ny4s_reg <= neg4y;
            px4_reg <= px3_reg; py4_reg <= py3_reg;
            ax4_reg <= ax3_reg; ay4_reg <= ay3_reg;
            bx4_reg <= bx3_reg; by4_reg <= by3_reg;
            den4_reg <= (den3_reg == '0) ? DW'(1) : den3_reg;
            mxl4_reg <= LPW'(dxm) * LPW'(nummag[NL-1:0]);
            mxh4_reg <= HPW'(dxm) * HPW'(nummag[DW-1:NL]);
            myl4_reg <= LPW'(dym) * LPW'(nummag[NL-1:0]);
            myh4_reg <= HPW'(dym) * HPW'(nummag[DW-1:NL]);
        end
    end

    // Stage 4b: combine the partial products into the dividends.
    localparam int SBW = 2 + 2 + 6 * CW;
    logic           v4b_reg;
    logic [SBW-1:0] sb4b_reg;
    logic [DW-1:0]  den4b_reg;
    logic [NW-1:0]  mx4b_reg, my4b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4b_reg <= 1'b0;
        end else if (en) begin
            v4b_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb4b_reg <= {cls4_reg, nx4s_reg, ny4s_reg, px4_reg, py4_reg,
                         ax4_reg, ay4_reg, bx4_reg, by4_reg};
            den4b_reg <= den4_reg;
            mx4b_reg <= NW'(mxl4_reg) + (NW'(mxh4_reg) << NL);
            my4b_reg <= NW'(myl4_reg) + (NW'(myh4_reg) << NL);
        end
    end

    // Divider pipeline: both axes, one bit per stage, sideband delayed alongside.
    logic [NW-1:0] xn [0:LAT_DIV];
    logic [NW-1:0] yn [0:LAT_DIV];
    logic [DW-1:0] xd [0:LAT_DIV];
    logic [DW-1:0] yd [0:LAT_DIV];
    logic [DW:0]   xr [0:LAT_DIV];
    logic [DW:0]   yr [0:LAT_DIV];
    logic [NW-1:0] xq [0:LAT_DIV];
    logic [NW-1:0] yq [0:LAT_DIV];

    assign xn[0] = mx4b_reg; assign yn[0] = my4b_reg;
    assign xd[0] = den4b_reg; assign yd[0] = den4b_reg;
    assign xr[0] = '0; assign yr[0] = '0;
    assign xq[0] = '0; assign yq[0] = '0;

    for (genvar g = 0; g < LAT_DIV; g++) begin : g_div
        psd_div_stage #(.NW(NW), .DW(DW), .BIT(NW-1-g)) u_dx (
            .aclk(aclk), .en(en),
            .num_in(xn[g]), .den_in(xd[g]), .rem_in(xr[g]), .quo_in(xq[g]),
            .num_out(xn[g+1]), .den_out(xd[g+1]), .rem_out(xr[g+1]), .quo_out(xq[g+1])
        );
        psd_div_stage #(.NW(NW), .DW(DW), .BIT(NW-1-g)) u_dy (
            .aclk(aclk), .en(en),
            .num_in(yn[g]), .den_in(yd[g]), .rem_in(yr[g]), .quo_in(yq[g]),
            .num_out(yn[g+1]), .den_out(yd[g+1]), .rem_out(yr[g+1]), .quo_out(yq[g+1])
        );
    end

    logic [SBW-1:0] sb_reg [0:LAT_DIV];
    logic           vd_reg [0:LAT_DIV];
    assign sb_reg[0] = sb4b_reg;
    assign vd_reg[0] = v4b_reg;
    for (genvar g = 0; g < LAT_DIV; g++) begin : g_sb
        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[g+1] <= sb_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[g+1] <= 1'b0;
            end else if (en) begin
                vd_reg[g+1] <= vd_reg[g];
            end
        end
    end

    // Stage 5: round quotients, pick closest point, form offsets.
    logic [1:0]           cls5;
    logic                 nsx, nsy;
    logic signed [CW-1:0] px5, py5, ax5, ay5, bx5, by5;
    logic [QW-1:0]        qxm, qym;
    logic signed [QW-1:0] cx5, cy5;

    always_comb begin
        {cls5, nsx, nsy, px5, py5, ax5, ay5, bx5, by5} = sb_reg[LAT_DIV];
        qxm = QW'(xq[LAT_DIV]) + QW'(({1'b0, xr[LAT_DIV]} << 1) >= (DW+2)'(xd[LAT_DIV]));
        qym = QW'(yq[LAT_DIV]) + QW'(({1'b0, yr[LAT_DIV]} << 1) >= (DW+2)'(yd[LAT_DIV]));
        case (cls5)
            psd_pkg::REGION_START: begin
                cx5 = QW'(ax5); cy5 = QW'(ay5);
            end
            psd_pkg::REGION_END: begin
                cx5 = QW'(bx5); cy5 = QW'(by5);
            end
            default: begin
                cx5 = QW'(ax5) + (nsx ? QW'(-qxm) : QW'(qxm));
                cy5 = QW'(ay5) + (nsy ? QW'(-qym) : QW'(qym));
            end
        endcase
    end

    logic                 v5_reg;
    logic [1:0]           cls5_reg;
    logic signed [QW-1:0] cx5_reg, cy5_reg, sx5_reg, sy5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= vd_reg[LAT_DIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls5_reg <= cls5;
            cx5_reg <= cx5; cy5_reg <= cy5;
            sx5_reg <= QW'(px5) - cx5;
            sy5_reg <= QW'(py5) - cy5;
        end
    end

    // Stage 6: squared distance and saturated closest point.
    localparam logic signed [QW-1:0] CMAX = QW'((65'sd1 <<< (CW-1)) - 1);
    localparam logic signed [QW-1:0] CMIN = -CMAX - QW'(1);

    logic [QW-1:0]        sxm, sym;
    logic [1:0]           cls6;
    logic signed [CW-1:0] ox6, oy6;

    always_comb begin
        sxm = sx5_reg[QW-1] ? QW'(-sx5_reg) : QW'(sx5_reg);
        sym = sy5_reg[QW-1] ? QW'(-sy5_reg) : QW'(sy5_reg);
        cls6 = cls5_reg;
        ox6 = CW'(cx5_reg);
        oy6 = CW'(cy5_reg);
        if (cx5_reg > CMAX) begin
            ox6 = CW'(CMAX); cls6 = psd_pkg::REGION_SATURATED;
        end else if (cx5_reg < CMIN) begin
            ox6 = CW'(CMIN); cls6 = psd_pkg::REGION_SATURATED;
        end
        if (cy5_reg > CMAX) begin
            oy6 = CW'(CMAX); cls6 = psd_pkg::REGION_SATURATED;
        end else if (cy5_reg < CMIN) begin
            oy6 = CW'(CMIN); cls6 = psd_pkg::REGION_SATURATED;
        end
    end

    logic                 v6_reg;
    logic [1:0]           cls6_reg;
    logic signed [CW-1:0] ox6_reg, oy6_reg;
    logic [SW-1:0]        sqx6_reg, sqy6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls6_reg <= cls6;
            ox6_reg <= ox6; oy6_reg <= oy6;
            sqx6_reg <= SW'(sxm) * SW'(sxm);
            sqy6_reg <= SW'(sym) * SW'(sym);
        end
    end

    // Square root pipeline on the sum of squares.
    logic [SW-1:0] rad [0:LAT_SQ];
    logic [SW-1:0] srm [0:LAT_SQ];
    logic [RW-1:0] rt  [0:LAT_SQ];
    localparam int OBW = 2 + 2 * CW;
    logic [OBW-1:0] ob [0:LAT_SQ];
    logic           vs [0:LAT_SQ];

    assign rad[0] = sqx6_reg + sqy6_reg;
    assign srm[0] = '0;
    assign rt[0]  = '0;
    assign ob[0]  = {cls6_reg, ox6_reg, oy6_reg};
    assign vs[0]  = v6_reg;

    for (genvar g = 0; g < LAT_SQ; g++) begin : g_sq
        psd_sqrt_stage #(.SW(SW), .RW(RW), .BIT(RW-1-g)) u_sq (
            .aclk(aclk), .en(en),
            .rad_in(rad[g]), .rem_in(srm[g]), .root_in(rt[g]),
            .rad_out(rad[g+1]), .rem_out(srm[g+1]), .root_out(rt[g+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                ob[g+1] <= ob[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs[g+1] <= 1'b0;
            end else if (en) begin
                vs[g+1] <= vs[g];
            end
        end
    end

    // Output stage: round the root to nearest and saturate.
    localparam logic [RW:0] DMAX = (RW+1)'((66'd1 << (CW+1)) - 1);
    logic [RW:0] droot;
    always_comb begin
        droot = (RW+1)'(rt[LAT_SQ]) + (RW+1)'(srm[LAT_SQ] > SW'(rt[LAT_SQ]));
        if (droot > DMAX) begin
            droot = DMAX;
        end
    end

    logic            m_tvalid_reg;
    logic [OW-1:0]   m_tdata_reg;
    logic [1:0]      ocls;
    logic [CW-1:0]   oxo, oyo;

    always_comb begin
        {ocls, oxo, oyo} = ob[LAT_SQ];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vs[LAT_SQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= OW'({ocls, oyo, oxo, droot[CW:0]});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PSD_ASSERT_IMPL(a_ready_follows_out, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input accepted during output stall")
    `PSD_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `PSD_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, v1_reg, "accepted request did not enter the pipeline")

endmodule

`default_nettype wire

[rtl/core/psd_div_stage.sv]
// ============================================================================
// Restoring divider stage
// One quotient bit per stage, registered, with stall control.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psd_div_stage #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int BIT = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [DW:0]   rem_in,
    input  wire logic [NW-1:0] quo_in,
    output logic [NW-1:0]      num_out,
    output logic [DW-1:0]      den_out,
    output logic [DW:0]        rem_out,
    output logic [NW-1:0]      quo_out
);

    logic [DW+1:0] shifted;
    logic [DW+1:0] diff;

    always_comb begin
        shifted = {rem_in, num_in[BIT]};
        diff    = shifted - {2'b00, den_in};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_out <= num_in;
            den_out <= den_in;
            if (!diff[DW+1]) begin
                rem_out <= diff[DW:0];
                quo_out <= quo_in | (NW'(1) << BIT);
            end else begin
                rem_out <= shifted[DW:0];
                quo_out <= quo_in;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/psd_sqrt_stage.sv]
// ============================================================================
// Square root stage
// Decides one result bit per stage by the restoring digit method.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt_stage #(
    parameter int SW = 8,
    parameter int RW = 4,
    parameter int BIT = 0
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [SW-1:0] rad_in,
    input  wire logic [SW-1:0] rem_in,
    input  wire logic [RW-1:0] root_in,
    output logic [SW-1:0]      rad_out,
    output logic [SW-1:0]      rem_out,
    output logic [RW-1:0]      root_out
);

    logic [SW+1:0] cur;
    logic [SW+1:0] trial;
    logic [SW+1:0] diff;

    always_comb begin
        cur   = {rem_in, rad_in[2*BIT+1], rad_in[2*BIT]};
        trial = (SW+2)'({root_in, 2'b01});
        diff  = cur - trial;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_out <= rad_in;
            if (cur >= trial) begin
                rem_out  <= diff[SW-1:0];
                root_out <= {root_in[RW-2:0], 1'b1};
            end else begin
                rem_out  <= cur[SW-1:0];
                root_out <= {root_in[RW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire
